// ===== rtl/rc6_pkg.sv =====
// ----------------------------------------------------------------------------
// RC6 package
// Item types, configuration register indexes, key schedule constants and
// the rotate helpers shared by the RC6 block cipher modules.
// ----------------------------------------------------------------------------
package rc6_pkg;

	// Default configuration of the cipher.
	localparam int ROUNDS_DEF        = 20;
	localparam int MAX_KEY_BYTES_DEF = 32;

	// Magic constants of the RC6 key schedule.
	localparam logic [31:0] P32 = 32'hB7E15163;
	localparam logic [31:0] Q32 = 32'h9E3779B9;

	// Number of 64-bit key registers.
	localparam int KEY_REGS = 4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES_0_7   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES_8_15  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES_16_23 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES_24_31 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH      = 3'd4;

	localparam logic [5:0] KEY_LENGTH_RESET = 6'd16;

	// Command codes.
	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	typedef logic [KEY_REGS-1:0][63:0] key_regs_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] in_word_a;
		logic [31:0] in_word_b;
		logic [31:0] in_word_c;
		logic [31:0] in_word_d;
	} in_item_t;

	typedef struct packed {
		logic [31:0] out_word_a;
		logic [31:0] out_word_b;
		logic [31:0] out_word_c;
		logic [31:0] out_word_d;
	} out_item_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] w;
		w = {x, x} << n;
		return w[63:32];
	endfunction

	function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] w;
		w = {x, x} >> n;
		return w[31:0];
	endfunction

endpackage

// ===== rtl/rc6_mix_unit.sv =====
// ----------------------------------------------------------------------------
// RC6 mix unit
// Computes the two quadratic mixes rotl(x * (2x + 1), 5) of one round and
// registers them for the following update cycle.
// ----------------------------------------------------------------------------
module rc6_mix_unit (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] x_t,
	input  logic [31:0] x_u,
	output logic [31:0] t_q,
	output logic [31:0] u_q
);
	import rc6_pkg::*;

	logic [31:0] prod_t;
	logic [31:0] prod_u;

	// Only the low 32 bits of each product are kept.
	assign prod_t = x_t * {x_t[30:0], 1'b1};
	assign prod_u = x_u * {x_u[30:0], 1'b1};

	always_ff @(posedge clk) begin
		if (en) begin
			t_q <= rotl32(prod_t, 5'd5);
			u_q <= rotl32(prod_u, 5'd5);
		end
	end

endmodule

// ===== rtl/rc6_key_sched.sv =====
// ----------------------------------------------------------------------------
// RC6 key schedule
// Packs the key bytes into words and runs the standard mixing passes that
// fill the round key memory, one mixing step per pass through K_A and K_B.
// ----------------------------------------------------------------------------
module rc6_key_sched #(
	parameter int ROUNDS        = rc6_pkg::ROUNDS_DEF,
	parameter int MAX_KEY_BYTES = rc6_pkg::MAX_KEY_BYTES_DEF,
	localparam int NUM_RK       = 2 * ROUNDS + 4,
	localparam int RKW          = $clog2(NUM_RK)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rc6_pkg::key_regs_t key,
	input  logic [5:0]        key_length,
	output logic              done,
	output logic              rk_we,
	output logic [RKW-1:0]    rk_waddr,
	output logic [31:0]       rk_wdata,
	output logic [RKW-1:0]    rk_raddr,
	input  logic [31:0]       rk_rdata
);
	import rc6_pkg::*;

	localparam int KW      = (MAX_KEY_BYTES + 3) / 4;
	localparam int LW      = (KW > 1) ? $clog2(KW) : 1;
	localparam int NWW     = $clog2(KW + 1);
	localparam int TOT_MAX = 3 * ((KW > NUM_RK) ? KW : NUM_RK);
	localparam int CW      = $clog2(TOT_MAX);

	typedef enum logic [1:0] {
		K_IDLE,
		K_LOAD,
		K_A,
		K_B
	} ks_state_t;

	ks_state_t      state_q;
	logic [31:0]    l_q [KW];
	logic [31:0]    a_q;
	logic [31:0]    b_q;
	logic [31:0]    sinit_q;
	logic           first_pass_q;
	logic [RKW-1:0] i_q;
	logic [LW-1:0]  j_q;
	logic [NWW-1:0] nwords_q;
	logic [CW-1:0]  step_q;
	logic [CW-1:0]  last_step_q;
	logic           done_q;

	logic [5:0]     len_sat;
	logic [6:0]     len_plus;
	logic [NWW-1:0] nwords_calc;
	logic [CW-1:0]  mx;
	logic           i_last;
	logic           j_last;
	logic [31:0]    s_val;
	logic [31:0]    a_new;
	logic [31:0]    ab_sum;
	logic [31:0]    b_new;

	assign len_sat     = (key_length > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : key_length;
	assign len_plus    = {1'b0, len_sat} + 7'd3;
	assign nwords_calc = (len_plus[6:2] == 5'd0) ? NWW'(1) : NWW'(len_plus[6:2]);
	assign mx          = (CW'(nwords_calc) > CW'(NUM_RK)) ? CW'(nwords_calc) : CW'(NUM_RK);

	assign i_last = (i_q == RKW'(NUM_RK - 1));
	assign j_last = (NWW'(j_q) == nwords_q - NWW'(1));

	assign s_val  = first_pass_q ? sinit_q : rk_rdata;
	assign a_new  = rotl32(s_val + a_q + b_q, 5'd3);
	assign ab_sum = a_q + b_q;
	assign b_new  = rotl32(l_q[j_q] + ab_sum, ab_sum[4:0]);

	assign done     = done_q;
	assign rk_we    = (state_q == K_A);
	assign rk_waddr = i_q;
	assign rk_wdata = a_new;

	// The memory read is registered, so the address of the next step goes out
	// in the K_B state, ahead of the K_A state that uses it.
	always_comb begin
		rk_raddr = '0;
		if (state_q == K_B && !i_last) begin
			rk_raddr = i_q + RKW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= K_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				K_IDLE: begin
					if (start) begin
						state_q <= K_LOAD;
					end
				end
				K_LOAD: begin
					state_q <= K_A;
				end
				K_A: begin
					state_q <= K_B;
				end
				K_B: begin
					if (step_q == last_step_q) begin
						done_q  <= 1'b1;
						state_q <= K_IDLE;
					end else begin
						state_q <= K_A;
					end
				end
				default: begin
					state_q <= K_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			K_LOAD: begin
				for (int w = 0; w < KW; w++) begin
					for (int b = 0; b < 4; b++) begin
						l_q[w][8*b +: 8] <= (6'(4 * w + b) < len_sat) ?
							key[(4 * w + b) / 8][8 * ((4 * w + b) % 8) +: 8] : 8'h00;
					end
				end
				a_q          <= '0;
				b_q          <= '0;
				i_q          <= '0;
				j_q          <= '0;
				step_q       <= '0;
				sinit_q      <= P32;
				first_pass_q <= 1'b1;
				nwords_q     <= nwords_calc;
				last_step_q  <= mx * CW'(3) - CW'(1);
			end
			K_A: begin
				a_q     <= a_new;
				sinit_q <= sinit_q + Q32;
			end
			K_B: begin
				l_q[j_q] <= b_new;
				b_q      <= b_new;
				step_q   <= step_q + CW'(1);
				if (i_last) begin
					i_q          <= '0;
					first_pass_q <= 1'b0;
				end else begin
					i_q <= i_q + RKW'(1);
				end
				j_q <= j_last ? '0 : j_q + LW'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/rc6_block_cipher.sv =====
// ----------------------------------------------------------------------------
// RC6 block cipher
// RC6-32 block cipher with a configurable key of up to 32 bytes and a cached
// key schedule, encrypting or decrypting one 128-bit block per item.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake               Payload       Direction
//   -------  ----------------------  ------------  ---------
//   in       in_valid / in_stall     in_item_t     into block
//   out      out_valid / out_stall   out_item_t    out of block
//   cfg      cfg_we                  cfg_index,    into block
//                                    cfg_data
//
// An item with valid round keys keeps the block busy until its result has
// been handed off to the output register; no new item is taken before that.
// Each round issues in T_ISSUE, where the shared mix unit registers its
// mixes while its two round keys are read from the key memory, and then
// updates the words in T_USE. The first item after reset or after any
// configuration write first rebuilds the round keys, one mixing step
// per pass through the K_A and K_B states of the key schedule.
// Reset clears the control state, loads the default key length of 16 bytes
// and marks the round keys stale. The round key memory itself is not reset.
// A stalled result sits in the output register while the next item is taken
// and processed; only the final hand-off waits for the output to drain.
//
module rc6_block_cipher #(
	parameter int ROUNDS        = rc6_pkg::ROUNDS_DEF,
	parameter int MAX_KEY_BYTES = rc6_pkg::MAX_KEY_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  rc6_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output rc6_pkg::out_item_t             out_item,
	input  logic                           cfg_we,
	input  logic [rc6_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                    cfg_data
);
	import rc6_pkg::*;

	localparam int NUM_RK = 2 * ROUNDS + 4;
	localparam int RKW    = $clog2(NUM_RK);
	localparam int PHW    = $clog2(ROUNDS + 2);

	typedef enum logic [2:0] {
		T_IDLE,
		T_KEYS,
		T_ISSUE,
		T_USE,
		T_DONE
	} top_state_t;

	// Configuration registers.
	key_regs_t  key_q;
	logic [5:0] key_len_q;

	top_state_t state_q;
	logic [PHW-1:0] ph_q;
	logic           keys_current_q;
	logic           out_valid_q;
	out_item_t      out_item_q;

	// Block words and command of the item at work.
	logic        cmd_q;
	logic [31:0] wa_q;
	logic [31:0] wb_q;
	logic [31:0] wc_q;
	logic [31:0] wd_q;

	// Round key memory with one write port and two registered read ports.
	logic [31:0]    rk_mem [NUM_RK];
	logic [31:0]    rd0_q;
	logic [31:0]    rd1_q;
	logic [RKW-1:0] rd_addr0;
	logic [RKW-1:0] rd_addr1;

	logic           ks_start;
	logic           ks_done;
	logic           ks_we;
	logic [RKW-1:0] ks_waddr;
	logic [31:0]    ks_wdata;
	logic [RKW-1:0] ks_raddr;

	logic [31:0]    mix_x_t;
	logic [31:0]    mix_x_u;
	logic [31:0]    mix_t;
	logic [31:0]    mix_u;

	logic           accept;
	logic           ph_last;
	logic           ph_round;
	logic           decrypt;
	logic           out_load;
	logic [PHW-1:0] key_base;
	logic [31:0]    enc_a;
	logic [31:0]    enc_c;

	assign in_stall  = (state_q != T_IDLE);
	assign accept    = in_valid && (state_q == T_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign ph_last  = (ph_q == PHW'(ROUNDS + 1));
	assign ph_round = (ph_q != '0) && !ph_last;
	assign decrypt  = (cmd_q == CMD_DECRYPT);
	assign out_load = (state_q == T_DONE) && (!out_valid_q || !out_stall);
	assign ks_start = accept && !keys_current_q;

	// Phase 0 is the input whitening, phases 1..ROUNDS are rounds and the last
	// phase is the output whitening. Each phase uses the key pair at
	// 2*base and 2*base+1; decryption walks the pairs from the top down.
	assign key_base = decrypt ? (PHW'(ROUNDS + 1) - ph_q) : ph_q;
	assign rd_addr0 = (state_q == T_KEYS) ? ks_raddr : {key_base, 1'b0};
	assign rd_addr1 = {key_base, 1'b1};

	// Decryption rotates the words first, so its mixes take the words that
	// become B and D, which are A and C before the rotation.
	assign mix_x_t = decrypt ? wa_q : wb_q;
	assign mix_x_u = decrypt ? wc_q : wd_q;

	assign enc_a = rotl32(wa_q ^ mix_t, mix_u[4:0]) + rd0_q;
	assign enc_c = rotl32(wc_q ^ mix_u, mix_t[4:0]) + rd1_q;

	always_ff @(posedge clk) begin
		if (ks_we) begin
			rk_mem[ks_waddr] <= ks_wdata;
		end
		rd0_q <= rk_mem[rd_addr0];
		rd1_q <= rk_mem[rd_addr1];
	end

	rc6_key_sched #(
		.ROUNDS        (ROUNDS),
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_key_sched (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (ks_start),
		.key        (key_q),
		.key_length (key_len_q),
		.done       (ks_done),
		.rk_we      (ks_we),
		.rk_waddr   (ks_waddr),
		.rk_wdata   (ks_wdata),
		.rk_raddr   (ks_raddr),
		.rk_rdata   (rd0_q)
	);

	rc6_mix_unit u_mix_unit (
		.clk (clk),
		.en  (state_q == T_ISSUE),
		.x_t (mix_x_t),
		.x_u (mix_x_u),
		.t_q (mix_t),
		.u_q (mix_u)
	);

	// Configuration writes. Writes to an index past the list change nothing
	// here but still mark the round keys stale below.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			key_len_q <= KEY_LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_BYTES_0_7:   key_q[0]  <= cfg_data;
				CFG_KEY_BYTES_8_15:  key_q[1]  <= cfg_data;
				CFG_KEY_BYTES_16_23: key_q[2]  <= cfg_data;
				CFG_KEY_BYTES_24_31: key_q[3]  <= cfg_data;
				CFG_KEY_LENGTH:      key_len_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: optional key rebuild, then the T_ISSUE and T_USE states for
	// each phase, then the hand-off into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= T_IDLE;
			ph_q           <= '0;
			keys_current_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (in_valid) begin
						ph_q    <= '0;
						state_q <= keys_current_q ? T_ISSUE : T_KEYS;
					end
				end
				T_KEYS: begin
					if (ks_done) begin
						keys_current_q <= 1'b1;
						state_q        <= T_ISSUE;
					end
				end
				T_ISSUE: begin
					state_q <= T_USE;
				end
				T_USE: begin
					if (ph_last) begin
						state_q <= T_DONE;
					end else begin
						ph_q    <= ph_q + PHW'(1);
						state_q <= T_ISSUE;
					end
				end
				T_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
			if (cfg_we) begin
				keys_current_q <= 1'b0;
			end
		end
	end

	// Block word datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_item.cmd;
			wa_q  <= in_item.in_word_a;
			wb_q  <= in_item.in_word_b;
			wc_q  <= in_item.in_word_c;
			wd_q  <= in_item.in_word_d;
		end else if (state_q == T_ISSUE) begin
			if (decrypt && ph_round) begin
				wa_q <= wd_q;
				wb_q <= wa_q;
				wc_q <= wb_q;
				wd_q <= wc_q;
			end
		end else if (state_q == T_USE) begin
			if (!decrypt) begin
				if (ph_q == '0) begin
					wb_q <= wb_q + rd0_q;
					wd_q <= wd_q + rd1_q;
				end else if (ph_last) begin
					wa_q <= wa_q + rd0_q;
					wc_q <= wc_q + rd1_q;
				end else begin
					wa_q <= wb_q;
					wb_q <= enc_c;
					wc_q <= wd_q;
					wd_q <= enc_a;
				end
			end else begin
				if (ph_q == '0) begin
					wa_q <= wa_q - rd0_q;
					wc_q <= wc_q - rd1_q;
				end else if (ph_last) begin
					wb_q <= wb_q - rd0_q;
					wd_q <= wd_q - rd1_q;
				end else begin
					wc_q <= rotr32(wc_q - rd1_q, mix_t[4:0]) ^ mix_u;
					wa_q <= rotr32(wa_q - rd0_q, mix_u[4:0]) ^ mix_t;
				end
			end
		end
		if (out_load) begin
			out_item_q.out_word_a <= wa_q;
			out_item_q.out_word_b <= wb_q;
			out_item_q.out_word_c <= wc_q;
			out_item_q.out_word_d <= wd_q;
		end
	end

endmodule

// ===== rtl/rc6_checker.sv =====
// ----------------------------------------------------------------------------
// RC6 port checker
// Concurrent assertions on the ports of the RC6 block cipher, bound to the
// top level.
// ----------------------------------------------------------------------------
module rc6_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input rc6_pkg::out_item_t out_item
);
	import rc6_pkg::*;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result item was withdrawn");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_item))
		else $error("stalled result item changed");

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall)
		else $error("input taken again while an item is at work");

	// No result can appear right after an item is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result item appeared too early");

endmodule

bind rc6_block_cipher rc6_checker u_rc6_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// RC6 block cipher testbench
// Drives 128-bit blocks through the cipher under a series of keys, from the
// empty key to over-long key lengths, with random idling and stalls on both
// channels. A scoreboard class holds its own key schedule and cipher
// rounds, predicts every result and compares it word by word.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rc6_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 6;
	localparam int NUM_RK         = 2 * ROUNDS_DEF + 4;
	localparam int MAX_KEY_WORDS  = MAX_KEY_BYTES_DEF / 4;
	localparam int LOG_WORD       = 5;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 4 * (2 * ROUNDS_DEF + 6);
	localparam int LONG_HOLD      = 400;
	localparam int NUM_SETTINGS   = 14;
	localparam int PHASE_BLOCKS   = 130;
	localparam int LIMIT_CYCLES   = 1_500_000;
	localparam int KEY_LEN_RANDOM = -1;
	// The index space is wider than the register list; the top indexes name
	// no register at all.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

	// ------------------------------------------------------------------------
	// Scoreboard: keeps a private copy of the key registers and the round
	// keys, predicts the transformed block for every accepted item and checks
	// results against the oldest outstanding prediction.
	// ------------------------------------------------------------------------
	class rc6_scoreboard;
		bit [63:0]  key_reg [KEY_REGS];
		bit [5:0]   key_len;
		bit [31:0]  round_key [NUM_RK];
		bit         keys_ready;
		out_item_t  expected_q [$];
		int         mismatches;
		int         checked;
		int         accepted;

		function new();
			foreach (key_reg[n])
				key_reg[n] = '0;
			key_len    = KEY_LENGTH_RESET;
			keys_ready = 1'b0;
			mismatches = 0;
			checked    = 0;
			accepted   = 0;
		endfunction

		// Any write, even to an index that names no register, makes the
		// cipher rebuild its round keys before the next block.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
			if (idx < KEY_REGS)
				key_reg[idx] = data;
			else if (idx == CFG_KEY_LENGTH)
				key_len = data[5:0];
			keys_ready = 1'b0;
		endfunction

		static function bit [31:0] rol(bit [31:0] x, bit [4:0] n);
			if (n == 0)
				return x;
			return (x << n) | (x >> (6'd32 - n));
		endfunction

		static function bit [31:0] ror(bit [31:0] x, bit [4:0] n);
			if (n == 0)
				return x;
			return (x >> n) | (x << (6'd32 - n));
		endfunction

		// x * (2x + 1) modulo 2^32, rotated left by lg(w).
		static function bit [31:0] mix(bit [31:0] x);
			bit [31:0] p;
			p = x * {x[30:0], 1'b1};
			return rol(p, LOG_WORD);
		endfunction

		function void expand_keys();
			bit [31:0]   kw [MAX_KEY_WORDS];
			bit [31:0]   a;
			bit [31:0]   b;
			bit [31:0]   s;
			int unsigned len;
			int unsigned nw;
			int unsigned total;
			int unsigned i;
			int unsigned j;
			len = (key_len > MAX_KEY_BYTES_DEF) ? MAX_KEY_BYTES_DEF : key_len;
			foreach (kw[n])
				kw[n] = '0;
			for (int n = 0; n < len; n++)
				kw[n / 4][8 * (n % 4) +: 8] = key_reg[n / 8][8 * (n % 8) +: 8];
			nw = (len + 3) / 4;
			if (nw == 0)
				nw = 1;
			round_key[0] = P32;
			for (int n = 1; n < NUM_RK; n++)
				round_key[n] = round_key[n - 1] + Q32;
			total = 3 * ((nw > NUM_RK) ? nw : NUM_RK);
			a = '0;
			b = '0;
			i = 0;
			j = 0;
			repeat (total) begin
				round_key[i] = rol(round_key[i] + a + b, 5'd3);
				a = round_key[i];
				s = a + b;
				kw[j] = rol(kw[j] + s, s[4:0]);
				b = kw[j];
				i = (i + 1) % NUM_RK;
				j = (j + 1) % nw;
			end
			keys_ready = 1'b1;
		endfunction

		function out_item_t encrypt(in_item_t blk);
			bit [31:0] a, b, c, d, t, u, x;
			out_item_t res;
			a = blk.in_word_a;
			b = blk.in_word_b + round_key[0];
			c = blk.in_word_c;
			d = blk.in_word_d + round_key[1];
			for (int r = 1; r <= ROUNDS_DEF; r++) begin
				t = mix(b);
				u = mix(d);
				a = rol(a ^ t, u[4:0]) + round_key[2 * r];
				c = rol(c ^ u, t[4:0]) + round_key[2 * r + 1];
				x = a;
				a = b;
				b = c;
				c = d;
				d = x;
			end
			res.out_word_a = a + round_key[2 * ROUNDS_DEF + 2];
			res.out_word_b = b;
			res.out_word_c = c + round_key[2 * ROUNDS_DEF + 3];
			res.out_word_d = d;
			return res;
		endfunction

		function out_item_t decrypt(in_item_t blk);
			bit [31:0] a, b, c, d, t, u, x;
			out_item_t res;
			a = blk.in_word_a - round_key[2 * ROUNDS_DEF + 2];
			b = blk.in_word_b;
			c = blk.in_word_c - round_key[2 * ROUNDS_DEF + 3];
			d = blk.in_word_d;
			for (int r = ROUNDS_DEF; r >= 1; r--) begin
				x = d;
				d = c;
				c = b;
				b = a;
				a = x;
				u = mix(d);
				t = mix(b);
				c = ror(c - round_key[2 * r + 1], t[4:0]) ^ u;
				a = ror(a - round_key[2 * r], u[4:0]) ^ t;
			end
			res.out_word_a = a;
			res.out_word_b = b - round_key[0];
			res.out_word_c = c;
			res.out_word_d = d - round_key[1];
			return res;
		endfunction

		function void note_input(in_item_t blk);
			if (!keys_ready)
				expand_keys();
			accepted++;
			expected_q.push_back((blk.cmd == CMD_ENCRYPT) ? encrypt(blk) : decrypt(blk));
		endfunction

		task report(string msg);
			$display("[%0t] ERROR: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result %h with no block outstanding", got));
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.out_word_a !== want.out_word_a)
				report($sformatf("result %0d word A: got %h, want %h", checked,
					got.out_word_a, want.out_word_a));
			if (got.out_word_b !== want.out_word_b)
				report($sformatf("result %0d word B: got %h, want %h", checked,
					got.out_word_b, want.out_word_b));
			if (got.out_word_c !== want.out_word_c)
				report($sformatf("result %0d word C: got %h, want %h", checked,
					got.out_word_c, want.out_word_c));
			if (got.out_word_d !== want.out_word_d)
				report($sformatf("result %0d word D: got %h, want %h", checked,
					got.out_word_d, want.out_word_d));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Block connections. Every input has a known value from time zero.
	// ------------------------------------------------------------------------
	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_item   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_item;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data  = '0;

	rc6_block_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rc6_scoreboard sb = new();

	// Idle rates in percent for the sender and the receiver; the main
	// sequence changes them from phase to phase.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	// Long receiver hold-off: the main sequence raises the request and the
	// receiver process counts the stall out cycle by cycle.
	bit long_hold_req = 1'b0;
	int hold_left     = 0;
	int settings_used = 0;

	// Key length of each key setting; the last one is drawn at random over
	// the whole six-bit range.
	int key_len_plan [NUM_SETTINGS] = '{0, 1, 3, 4, 5, 8, 13, 16, 24, 31, 32, 33, 63,
		KEY_LEN_RANDOM};

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Run limit: far beyond the slowest correct run, key rebuilds and long
	// stalls included.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("Run timed out with %0d results still outstanding.",
			sb.expected_q.size());
		$display("tb failed");
		$finish;
	end

	// Receiver: the stall changes only at the falling edge, either counted
	// down during a long hold-off or drawn from the current idle rate.
	always @(negedge clk) begin
		if (long_hold_req) begin
			hold_left = LONG_HOLD;
			long_hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// Results are taken at the rising edge where valid is high and the stall
	// is low, and checked at once.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_item);
	end

	function automatic in_item_t make_block(logic cmd, logic [31:0] a, logic [31:0] b,
			logic [31:0] c, logic [31:0] d);
		in_item_t blk;
		blk.cmd       = cmd;
		blk.in_word_a = a;
		blk.in_word_b = b;
		blk.in_word_c = c;
		blk.in_word_d = d;
		return blk;
	endfunction

	// Mostly uniform words, with zero, all ones and single-bit words mixed in
	// so that the carries and rotations see their edge values often.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 32'd1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	// Offers one item. Entered and left at a falling edge; valid is only
	// changed there, and at most once per edge. The item counts as accepted
	// at the first rising edge with the stall low.
	task automatic drive_item(in_item_t blk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= blk;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(blk);
		@(negedge clk);
	endtask

	// Stops offering and waits until every outstanding block has come back,
	// then lets the block settle before anything else happens.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write: a single cycle with the write enable high, after which
	// the enable is driven low before the task returns, so that back-to-back
	// writes never touch the enable twice at the same edge.
	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Loads a complete key. The key length register gets random upper bits,
	// which the block must ignore. Some settings use an all-zero or all-ones
	// key, and every fourth one ends with a write to an index that names no
	// register, which must only force a rebuild of the round keys.
	task automatic load_key(int setting);
		logic [63:0] kdata;
		logic [63:0] len_word;
		int          len;
		len = key_len_plan[setting];
		if (len == KEY_LEN_RANDOM)
			len = $urandom_range(0, 63);
		for (int n = 0; n < KEY_REGS; n++) begin
			if (len == 16 && setting > 0)
				kdata = '0;
			else if (len == MAX_KEY_BYTES_DEF)
				kdata = '1;
			else
				kdata = {$urandom, $urandom};
			write_cfg(n[CFG_IDX_W-1:0], kdata);
		end
		len_word = {$urandom, $urandom};
		len_word[5:0] = len[5:0];
		write_cfg(CFG_KEY_LENGTH, len_word);
		if (setting % 4 == 3)
			write_cfg(CFG_IDX_W'($urandom_range(CFG_KEY_LENGTH + 1, CFG_IDX_LAST)),
				{$urandom, $urandom});
		settings_used++;
	endtask

	// Random blocks under the current key. A phase may start a long receiver
	// hold-off a third of the way in, while the sender keeps offering so the
	// block backs up, or pause the sender halfway until all results are back.
	task automatic run_blocks(int count, bit with_hold, bit with_pause);
		for (int n = 0; n < count; n++) begin
			if (with_hold && n == count / 3)
				long_hold_req = 1'b1;
			if (with_pause && n == count / 2)
				wait_drained();
			drive_item(make_block(1'($urandom_range(0, 1)), pick_word(), pick_word(),
				pick_word(), pick_word()));
		end
	endtask

	// Directed blocks under the reset key: all-zero key, sixteen bytes long.
	task automatic run_directed();
		in_item_t blk [$];
		blk.push_back(make_block(CMD_ENCRYPT, '0, '0, '0, '0));
		blk.push_back(make_block(CMD_DECRYPT, '0, '0, '0, '0));
		blk.push_back(make_block(CMD_ENCRYPT, '1, '1, '1, '1));
		blk.push_back(make_block(CMD_DECRYPT, '1, '1, '1, '1));
		blk.push_back(make_block(CMD_ENCRYPT, '1, '0, '0, '0));
		blk.push_back(make_block(CMD_ENCRYPT, '0, '1, '0, '0));
		blk.push_back(make_block(CMD_ENCRYPT, '0, '0, '1, '0));
		blk.push_back(make_block(CMD_ENCRYPT, '0, '0, '0, '1));
		blk.push_back(make_block(CMD_DECRYPT, '1, '0, '1, '0));
		blk.push_back(make_block(CMD_DECRYPT, '0, '1, '0, '1));
		blk.push_back(make_block(CMD_ENCRYPT, 32'hAAAAAAAA, 32'h55555555,
			32'hAAAAAAAA, 32'h55555555));
		blk.push_back(make_block(CMD_DECRYPT, 32'h55555555, 32'hAAAAAAAA,
			32'h55555555, 32'hAAAAAAAA));
		blk.push_back(make_block(CMD_ENCRYPT, 32'h00000001, 32'h80000000,
			32'h00000001, 32'h80000000));
		blk.push_back(make_block(CMD_DECRYPT, 32'h80000000, 32'h00000001,
			32'h80000000, 32'h00000001));
		blk.push_back(make_block(CMD_ENCRYPT, 32'h35241302, 32'h79685746,
			32'hBDAC9B8A, 32'hF1E0DFCE));
		blk.push_back(make_block(CMD_DECRYPT, 32'h35241302, 32'h79685746,
			32'hBDAC9B8A, 32'hF1E0DFCE));
		foreach (blk[n])
			drive_item(blk[n]);
	endtask

	// Main sequence. Reset is applied once; then the directed blocks run
	// under the reset key, followed by one random phase per key setting.
	// The first third of the settings idle the sender lightly and the
	// receiver heavily, the second third the other way round, the rest run
	// without idling. Keys are only changed once the block has drained.
	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		tx_idle_pct = 10;
		rx_idle_pct = 56;
		run_directed();

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			if (s < NUM_SETTINGS / 3) begin
				tx_idle_pct = 10;
				rx_idle_pct = 56;
			end else if (s < 2 * NUM_SETTINGS / 3) begin
				tx_idle_pct = 56;
				rx_idle_pct = 10;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			wait_drained();
			load_key(s);
			run_blocks(PHASE_BLOCKS, s == 2 || s == 11, s == 7 || s == 12);
		end

		// Let everything drain, then watch a while longer for stray results.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));

		$display("Covered %0d blocks, encrypt and decrypt, under %0d key settings from the",
			sb.accepted, settings_used + 1);
		$display("empty key to over-long lengths; %0d results checked, %0d mismatches.",
			sb.checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rc6_pkg.sv
rtl/rc6_mix_unit.sv
rtl/rc6_key_sched.sv
rtl/rc6_block_cipher.sv
rtl/rc6_checker.sv
tb/tb.sv
